// ----- design/ufc_pkg.sv -----
package ufc_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       error;
        logic       last;
    } t_out_req;

    typedef enum logic [1:0] {
        CMD_CODE      = 2'd0,
        CMD_ERROR     = 2'd1,
        CMD_FLUSH     = 2'd2,
        CMD_ERR_FLUSH = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [20:0] value;
    } t_cmd;

    localparam logic [20:0] MAX_POINT = 21'h10FFFF;

    // Weights above the largest code value are never selected.
    function automatic logic [20:0] fib_weight(input logic [4:0] idx);
        logic [20:0] w;
        case (idx)
            5'd0:    w = 21'd1;
            5'd1:    w = 21'd2;
            5'd2:    w = 21'd3;
            5'd3:    w = 21'd5;
            5'd4:    w = 21'd8;
            5'd5:    w = 21'd13;
            5'd6:    w = 21'd21;
            5'd7:    w = 21'd34;
            5'd8:    w = 21'd55;
            5'd9:    w = 21'd89;
            5'd10:   w = 21'd144;
            5'd11:   w = 21'd233;
            5'd12:   w = 21'd377;
            5'd13:   w = 21'd610;
            5'd14:   w = 21'd987;
            5'd15:   w = 21'd1597;
            5'd16:   w = 21'd2584;
            5'd17:   w = 21'd4181;
            5'd18:   w = 21'd6765;
            5'd19:   w = 21'd10946;
            5'd20:   w = 21'd17711;
            5'd21:   w = 21'd28657;
            5'd22:   w = 21'd46368;
            5'd23:   w = 21'd75025;
            5'd24:   w = 21'd121393;
            5'd25:   w = 21'd196418;
            5'd26:   w = 21'd317811;
            5'd27:   w = 21'd514229;
            5'd28:   w = 21'd832040;
            5'd29:   w = 21'd1346269;
            default: w = 21'h1FFFFF;
        endcase
        return w;
    endfunction

endpackage

// ----- design/ufc_queue.sv -----
module ufc_queue #(
    parameter int W  = 8,
    parameter int AW = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2**AW];
    logic [AW:0]  r_wr;
    logic [AW:0]  r_rd;
    logic         do_push;
    logic         do_pop;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

// ----- design/ufc_front.sv -----
module ufc_front import ufc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_in_req i_item,
    input  logic    i_cmd_full,
    output logic    o_cmd_push,
    output t_cmd    o_cmd
);

    logic [20:0] r_accum;
    logic [1:0]  r_due;
    logic        r_err;
    logic [20:0] n_accum;
    logic [1:0]  n_due;
    logic        n_err;
    logic [20:0] dec_accum;
    logic [1:0]  dec_due;
    logic        complete;
    logic        bad;
    logic        accept;
    logic [7:0]  b;

    assign accept = i_push && !i_cmd_full;
    assign b      = i_item.in_byte;

    always_comb begin
        n_accum    = r_accum;
        n_due      = r_due;
        n_err      = r_err;
        o_cmd_push = 1'b0;
        o_cmd.op   = CMD_CODE;
        o_cmd.value = '0;
        dec_accum  = r_accum;
        dec_due    = r_due;
        complete   = 1'b0;
        bad        = 1'b0;
        if (r_due == 2'd0) begin
            if (b[7] == 1'b0) begin
                dec_accum = {13'd0, b};
                complete  = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                dec_accum = {16'd0, b[4:0]};
                dec_due   = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_accum = {17'd0, b[3:0]};
                dec_due   = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                dec_accum = {18'd0, b[2:0]};
                dec_due   = 2'd3;
            end else begin
                bad = 1'b1;
            end
        end else if (b[7:6] == 2'b10) begin
            dec_accum = {r_accum[14:0], b[5:0]};
            dec_due   = r_due - 2'd1;
            complete  = (r_due == 2'd1);
        end else begin
            bad = 1'b1;
        end
        if (accept) begin
            o_cmd_push = 1'b1;
            if (i_item.end_of_input) begin
                o_cmd.op = (r_err || r_due != 2'd0) ? CMD_ERR_FLUSH : CMD_FLUSH;
                n_accum  = '0;
                n_due    = '0;
                n_err    = 1'b0;
            end else if (r_err) begin
                o_cmd.op = CMD_ERROR;
            end else if (bad || (complete && dec_accum > MAX_POINT)) begin
                o_cmd.op = CMD_ERROR;
                n_err    = 1'b1;
            end else if (complete) begin
                o_cmd.op    = CMD_CODE;
                o_cmd.value = dec_accum + 21'd1;
                n_accum     = '0;
                n_due       = '0;
            end else begin
                o_cmd_push = 1'b0;
                n_accum    = dec_accum;
                n_due      = dec_due;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_due   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_accum <= n_accum;
            r_due   <= n_due;
            r_err   <= n_err;
        end
    end

endmodule

// ----- design/ufc_back.sv -----
module ufc_back import ufc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_empty,
    input  t_cmd     i_cmd,
    output logic     o_cmd_pop,
    input  logic     i_out_full,
    output logic     o_out_push,
    output t_out_req o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_MERGE = 5'b00100,
        S_EMIT  = 5'b01000,
        S_ONE   = 5'b10000
    } t_back_state;

    t_back_state r_state, n_state;
    logic [39:0] r_store, n_store;
    logic [5:0]  r_pending, n_pending;
    logic [20:0] r_rem, n_rem;
    logic [2:0]  r_grp, n_grp;
    logic [31:0] r_code, n_code;
    logic [4:0]  r_top, n_top;
    logic        r_found, n_found;
    t_out_req    r_one, n_one;

    logic [2:0]  start_grp;
    logic [20:0] cv_rem;
    logic [31:0] cv_code;
    logic [4:0]  cv_top;
    logic        cv_found;
    logic [4:0]  idx;
    logic [20:0] w;
    logic [31:0] full_code;
    logic [5:0]  code_len;
    logic [39:0] shifted;
    logic [5:0]  merge_pending;

    always_comb begin
        start_grp = '0;
        for (int g = 1; g < 8; g++) begin
            if (fib_weight({3'(g), 2'b00}) <= i_cmd.value) begin
                start_grp = 3'(g);
            end
        end
    end

    // Greedy selection over the four weights of the current group, highest first.
    always_comb begin
        cv_rem   = r_rem;
        cv_code  = r_code;
        cv_top   = r_top;
        cv_found = r_found;
        idx      = '0;
        w        = '0;
        for (int j = 0; j < 4; j++) begin
            idx = {r_grp, 2'(3 - j)};
            w   = fib_weight(idx);
            if (w <= cv_rem) begin
                cv_rem       = cv_rem - w;
                cv_code[idx] = 1'b1;
                if (!cv_found) begin
                    cv_found = 1'b1;
                    cv_top   = idx;
                end
            end
        end
    end

    assign full_code     = r_code | (32'd1 << (r_top + 5'd1));
    assign code_len      = {1'b0, r_top} + 6'd2;
    assign shifted       = {8'd0, full_code} << r_pending[2:0];
    assign merge_pending = {3'd0, r_pending[2:0]} + code_len;

    always_comb begin
        n_state    = r_state;
        n_store    = r_store;
        n_pending  = r_pending;
        n_rem      = r_rem;
        n_grp      = r_grp;
        n_code     = r_code;
        n_top      = r_top;
        n_found    = r_found;
        n_one      = r_one;
        o_cmd_pop  = 1'b0;
        o_out_push = 1'b0;
        o_out      = r_one;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_CODE: begin
                            n_rem   = i_cmd.value;
                            n_grp   = start_grp;
                            n_code  = '0;
                            n_top   = '0;
                            n_found = 1'b0;
                            n_state = S_CONV;
                        end
                        CMD_ERROR: begin
                            n_one   = '{out_byte: 8'd0, error: 1'b1, last: 1'b1};
                            n_state = S_ONE;
                        end
                        CMD_ERR_FLUSH: begin
                            n_one     = '{out_byte: 8'd0, error: 1'b1, last: 1'b1};
                            n_store   = '0;
                            n_pending = '0;
                            n_state   = S_ONE;
                        end
                        CMD_FLUSH: begin
                            n_one     = '{out_byte: r_store[7:0], error: 1'b0, last: 1'b1};
                            n_store   = '0;
                            n_pending = '0;
                            if (r_pending != 6'd0) begin
                                n_state = S_ONE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                n_rem   = cv_rem;
                n_code  = cv_code;
                n_top   = cv_top;
                n_found = cv_found;
                if (r_grp == 3'd0) begin
                    n_state = S_MERGE;
                end else begin
                    n_grp = r_grp - 3'd1;
                end
            end
            S_MERGE: begin
                n_store   = r_store | shifted;
                n_pending = merge_pending;
                n_state   = (merge_pending >= 6'd8) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                o_out = '{out_byte: r_store[7:0], error: 1'b0, last: (r_pending < 6'd16)};
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_store    = {8'd0, r_store[39:8]};
                    n_pending  = r_pending - 6'd8;
                    if (r_pending < 6'd16) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ONE: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_store   <= '0;
            r_pending <= '0;
        end else begin
            r_state   <= n_state;
            r_store   <= n_store;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_grp   <= n_grp;
        r_code  <= n_code;
        r_top   <= n_top;
        r_found <= n_found;
        r_one   <= n_one;
    end

endmodule

// ----- design/utf8_to_fibonacci_encoder_core.sv -----
// UTF-8 to Fibonacci code transcoder.
// Input requests enter through push/full; a request carries one UTF-8 byte or an
// end-of-input marker. Result requests leave through empty/pop; while empty is low
// the oldest result is on o_result, and pop takes it.
// A front stage decodes UTF-8 and sends one command per finished character, error
// or end marker into a small command queue, so it takes a byte in every cycle
// while that queue has room. A back stage turns each code point plus one into its
// Zeckendorf code, four Fibonacci weights per cycle, and writes the packed bytes
// into a result queue at one byte per cycle while that queue has room.
// For a character the back stage fetches the command, runs conversion steps, one
// per group of four weights and as many as the magnitude of the code point asks,
// merges the code into its bit store and then emits each full output byte. An
// end marker gives a last byte only when bits are pending.
// When the receiver stalls, the result queue fills, the back stage waits, and full
// rises once the command queue is full too; nothing is lost.
// A synchronous reset empties both queues and clears all decoding and bit state.
module utf8_to_fibonacci_encoder_core import ufc_pkg::*; #(
    parameter int CMD_DEPTH_LOG2 = 1,
    parameter int OUT_DEPTH_LOG2 = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_req  i_item,
    output logic     empty,
    input  logic     pop,
    output t_out_req o_result
);

    logic     cmd_push;
    t_cmd     cmd_in;
    logic     cmd_full;
    logic     cmd_pop;
    t_cmd     cmd_out;
    logic     cmd_empty;
    logic     out_push;
    t_out_req out_in;
    logic     out_full;

    assign full = cmd_full;

    ufc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    ufc_queue #(
        .W  ($bits(t_cmd)),
        .AW (CMD_DEPTH_LOG2)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    ufc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_in)
    );

    ufc_queue #(
        .W  ($bits(t_out_req)),
        .AW (OUT_DEPTH_LOG2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ----- design/ufc_checker.sv -----
module ufc_checker import ufc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     full,
    input logic     empty,
    input logic     pop,
    input t_out_req o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error) |-> (o_result.out_byte == 8'd0 && o_result.last))
        else $error("error result with data or without last");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_result.last) |=> !empty)
        else $error("result queue ran dry inside a character");

endmodule

bind utf8_to_fibonacci_encoder_core ufc_checker u_checker (.*);
